FILE: sv/der_lsc_pkg.sv
// Shared types and constants for the strict DER low-S signature checker.
// No dependencies; imported by der_lsc_core and der_low_s_signature_check.
package der_lsc_pkg;

    localparam logic [7:0] TagSequence = 8'h30;
    localparam logic [7:0] TagInteger  = 8'h02;
    localparam logic [7:0] IntMaxLen   = 8'd33;
    localparam logic [6:0] CountMax    = 7'd127;
    localparam logic [7:0] MinSigBytes = 8'd8;

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    typedef struct packed {
        logic valid;
        logic ok;
    } verdict_t;

    // Half of the secp256k1 group order, most significant byte first.
    function automatic logic [7:0] half_n_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:  b = 8'h7f;
            5'd16: b = 8'h5d;
            5'd17: b = 8'h57;
            5'd18: b = 8'h6e;
            5'd19: b = 8'h73;
            5'd20: b = 8'h57;
            5'd21: b = 8'ha4;
            5'd22: b = 8'h50;
            5'd23: b = 8'h1d;
            5'd24: b = 8'hdf;
            5'd25: b = 8'he9;
            5'd26: b = 8'h2f;
            5'd27: b = 8'h46;
            5'd28: b = 8'h68;
            5'd29: b = 8'h1b;
            5'd30: b = 8'h20;
            5'd31: b = 8'ha0;
            default: b = 8'hff;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/der_lsc_core.sv
// Parser state and per-byte checks of the strict DER low-S signature checker.
// Depends on der_lsc_pkg; instantiated by der_low_s_signature_check.
module der_lsc_core #(
    parameter int MAX_SIG_BYTES = 72
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  take,
    input  logic [7:0]            sig_byte,
    input  logic                  last_byte,
    output der_lsc_pkg::verdict_t verdict
);
    import der_lsc_pkg::*;

    localparam logic [6:0] MaxBytes = 7'(MAX_SIG_BYTES);

    logic [6:0] count_reg, count_next, count_upd;
    logic [7:0] decl_reg, decl_next, decl_upd;
    logic [7:0] rlen_reg, rlen_next, rlen_upd;
    logic [6:0] stpos_reg, stpos_next, stpos_upd;
    logic [7:0] slen_reg, slen_next, slen_upd;
    logic       rzero_reg, rzero_next, rzero_upd;
    logic       szero_reg, szero_next, szero_upd;
    cmp_t       cmp_reg, cmp_next, cmp_upd;
    logic       failed_reg, failed_next, failed_upd;

    logic [6:0] pos;
    logic [6:0] k;
    logic [7:0] idx_w;
    logic [4:0] idx;
    logic [7:0] half_b;
    logic [7:0] len;
    logic       ok;

    assign pos    = count_reg;
    assign k      = pos - stpos_reg - 7'd2;
    assign idx_w  = {1'b0, k} + 8'd32 - slen_reg;
    assign idx    = idx_w[4:0];
    assign half_b = half_n_byte(idx);
    assign len    = {1'b0, pos} + 8'd1;

    always_comb begin
        decl_upd   = decl_reg;
        rlen_upd   = rlen_reg;
        stpos_upd  = stpos_reg;
        slen_upd   = slen_reg;
        rzero_upd  = rzero_reg;
        szero_upd  = szero_reg;
        cmp_upd    = cmp_reg;
        failed_upd = failed_reg;
        count_upd  = (pos == CountMax) ? CountMax : pos + 7'd1;

        if (pos >= MaxBytes) begin
            failed_upd = 1'b1;
        end else if (!failed_reg) begin
            case (pos)
                7'd0: begin
                    if (sig_byte != TagSequence) failed_upd = 1'b1;
                end
                7'd1: begin
                    decl_upd = sig_byte;
                end
                7'd2: begin
                    if (sig_byte != TagInteger) failed_upd = 1'b1;
                end
                7'd3: begin
                    rlen_upd = sig_byte;
                    if (sig_byte == 8'd0 || sig_byte > IntMaxLen) begin
                        failed_upd = 1'b1;
                    end else begin
                        stpos_upd = sig_byte[6:0] + 7'd4;
                    end
                end
                default: begin
                    if (pos == 7'd4) begin
                        if (sig_byte[7]) failed_upd = 1'b1;
                        rzero_upd = (sig_byte == 8'd0);
                    end
                    if (pos == 7'd5 && rlen_reg > 8'd1 && rzero_reg && !sig_byte[7]) begin
                        failed_upd = 1'b1;
                    end
                    if (stpos_reg >= 7'd5) begin
                        if (pos == stpos_reg) begin
                            if (sig_byte != TagInteger) failed_upd = 1'b1;
                        end else if (pos == stpos_reg + 7'd1) begin
                            slen_upd = sig_byte;
                            if (sig_byte == 8'd0 || sig_byte > IntMaxLen) begin
                                failed_upd = 1'b1;
                            end else if (sig_byte < 8'd32) begin
                                cmp_upd = CMP_LESS;
                            end
                        end else if (pos >= stpos_reg + 7'd2 && {1'b0, k} < slen_reg) begin
                            if (k == 7'd0) begin
                                if (sig_byte[7]) failed_upd = 1'b1;
                                szero_upd = (sig_byte == 8'd0);
                            end
                            if (k == 7'd1 && slen_reg > 8'd1 && szero_reg && !sig_byte[7]) begin
                                failed_upd = 1'b1;
                            end
                            if (slen_reg == IntMaxLen && k == 7'd0) begin
                                if (sig_byte != 8'd0) failed_upd = 1'b1;
                            end else if (cmp_reg == CMP_EQUAL) begin
                                if (sig_byte < half_b) begin
                                    cmp_upd = CMP_LESS;
                                end else if (sig_byte > half_b) begin
                                    cmp_upd = CMP_GREATER;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        ok = !failed_upd
            && len >= MinSigBytes
            && len <= {1'b0, MaxBytes}
            && decl_upd == len - 8'd2
            && ({1'b0, rlen_upd} + 9'd7) <= {1'b0, len}
            && ({2'b00, stpos_upd} + 9'd2 + {1'b0, slen_upd}) == {1'b0, len}
            && cmp_upd != CMP_GREATER;
    end

    assign verdict.valid = take && last_byte;
    assign verdict.ok    = ok;

    always_comb begin
        count_next  = count_reg;
        decl_next   = decl_reg;
        rlen_next   = rlen_reg;
        stpos_next  = stpos_reg;
        slen_next   = slen_reg;
        rzero_next  = rzero_reg;
        szero_next  = szero_reg;
        cmp_next    = cmp_reg;
        failed_next = failed_reg;
        if (take) begin
            if (last_byte) begin
                count_next  = '0;
                decl_next   = '0;
                rlen_next   = '0;
                stpos_next  = '0;
                slen_next   = '0;
                rzero_next  = 1'b0;
                szero_next  = 1'b0;
                cmp_next    = CMP_EQUAL;
                failed_next = 1'b0;
            end else begin
                count_next  = count_upd;
                decl_next   = decl_upd;
                rlen_next   = rlen_upd;
                stpos_next  = stpos_upd;
                slen_next   = slen_upd;
                rzero_next  = rzero_upd;
                szero_next  = szero_upd;
                cmp_next    = cmp_upd;
                failed_next = failed_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            decl_reg   <= '0;
            rlen_reg   <= '0;
            stpos_reg  <= '0;
            slen_reg   <= '0;
            rzero_reg  <= 1'b0;
            szero_reg  <= 1'b0;
            cmp_reg    <= CMP_EQUAL;
            failed_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            decl_reg   <= decl_next;
            rlen_reg   <= rlen_next;
            stpos_reg  <= stpos_next;
            slen_reg   <= slen_next;
            rzero_reg  <= rzero_next;
            szero_reg  <= szero_next;
            cmp_reg    <= cmp_next;
            failed_reg <= failed_next;
        end
    end

endmodule

FILE: sv/der_low_s_signature_check.sv
// Top level of the strict DER low-S ECDSA signature checker.
// Depends on der_lsc_pkg and der_lsc_core.
//
//   channel | direction | tdata                      | tlast
//   s_      | in        | [7:0] sig_byte             | last_byte
//   m_      | out       | [0] is_canonical, rest 0   | -
//
// One item per cycle sustained unless a last byte waits on a stalled result:
// an input register feeds the parser state update and the verdict logic, which load the result register.
// After the last byte is accepted, its verdict passes from the input register to the result register.
// aresetn is synchronous; reset empties both registers and restarts parsing.
// A stalled result holds only the stage behind it; other bytes keep flowing.
module der_low_s_signature_check #(
    parameter int MAX_SIG_BYTES = 72
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] sig_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] is_canonical, [7:1] zero
);
    import der_lsc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic       out_ok_reg;
    logic       out_free;
    logic       advance;
    verdict_t   verdict;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !in_last_reg);
    assign s_tready = !in_valid_reg || advance;

    der_lsc_core #(
        .MAX_SIG_BYTES(MAX_SIG_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (advance),
        .sig_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (verdict.valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (verdict.valid) begin
            out_ok_reg <= verdict.ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};

endmodule
